>>> sv/iprt_pkg.sv
// shared types and constants for the ipv4 route table lookup
`timescale 1ns / 1ps

package iprt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam int ADDR_W  = 32;
    localparam int IFACE_W = 2;
    localparam int COST_W  = 14;

    // routes at or above this metric are never chosen
    localparam logic [COST_W-1:0] COST_LIMIT = COST_W'(9999);

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_LOOKUP = 1'b1
    } route_op_t;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_HIT   = 2'd2,
        ST_MISS  = 2'd3
    } route_status_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gateway;
        logic [IFACE_W-1:0] iface;
        logic [COST_W-1:0]  cost;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic step;
    } match_ctl_t;

    typedef struct packed {
        logic   found;
        entry_t entry;
    } match_res_t;

endpackage

>>> sv/ipv4_route_table_lookup.sv
// ipv4 route table: an add's result is registered at the accepting edge
// a lookup of a table holding n routes reads them in state SCAN, one entry per cycle,
// through the single read port of the table memory and the shared compare unit
// then passes DRAIN and DONE; a lookup on an empty table misses at the accepting edge
// one item at a time: the input stalls until the result has been loaded
// reset (rst_n, asynchronous, active low) empties the table and the output register
`timescale 1ns / 1ps

module ipv4_route_table_lookup #(
    parameter int TABLE_DEPTH = iprt_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [iprt_pkg::ADDR_W-1:0]   dest_addr,
    input  logic [iprt_pkg::ADDR_W-1:0]   net_mask,
    input  logic [iprt_pkg::ADDR_W-1:0]   next_hop,
    input  logic [iprt_pkg::IFACE_W-1:0]  iface_index,
    input  logic [iprt_pkg::COST_W-1:0]   route_cost,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [iprt_pkg::ADDR_W-1:0]   hit_gateway,
    output logic [iprt_pkg::IFACE_W-1:0]  hit_iface,
    output logic [iprt_pkg::COST_W-1:0]   hit_cost,
    output logic [iprt_pkg::ADDR_W-1:0]   hit_dest,
    output logic [iprt_pkg::ADDR_W-1:0]   hit_mask
);
    import iprt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              step_reg, step_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    entry_t            out_entry_reg, out_entry_next;

    logic       accept;
    logic       out_free;
    logic       wr_en;
    entry_t     new_entry;
    entry_t     rd_data;
    match_ctl_t mctl;
    match_res_t mres;
    logic       last_issue;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    assign new_entry.dest    = dest_addr;
    assign new_entry.mask    = net_mask;
    assign new_entry.gateway = next_hop;
    assign new_entry.iface   = iface_index;
    assign new_entry.cost    = route_cost;

    assign wr_en = accept && (operation == OP_ADD) && (count_reg != FULL_COUNT);

    assign last_issue = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    assign mctl.clear = accept && (operation == OP_LOOKUP);
    assign mctl.step  = step_reg;

    iprt_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (new_entry),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    iprt_match_unit u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .addr  (addr_reg),
        .entry (rd_data),
        .res   (mres)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        step_next      = 1'b0;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        out_entry_next = out_entry_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_ADD)
                    begin
                        out_valid_next = 1'b1;
                        out_entry_next = '0;
                        if (count_reg == FULL_COUNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_ADDED;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_MISS;
                        out_entry_next = '0;
                    end
                    else
                    begin
                        addr_next  = dest_addr;
                        idx_next   = '0;
                        state_next = SCAN;
                    end
                end
            end
            SCAN:
            begin
                // read issued this cycle is compared in the next one
                step_next = 1'b1;
                if (last_issue)
                begin
                    state_next = DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            DRAIN:
            begin
                state_next = DONE;
            end
            DONE:
            begin
                out_valid_next = 1'b1;
                if (mres.found)
                begin
                    status_next    = ST_HIT;
                    out_entry_next = mres.entry;
                end
                else
                begin
                    status_next    = ST_MISS;
                    out_entry_next = '0;
                end
                state_next = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            step_reg      <= 1'b0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_ADDED;
            out_entry_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            out_entry_reg <= out_entry_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign hit_gateway = out_entry_reg.gateway;
    assign hit_iface   = out_entry_reg.iface;
    assign hit_cost    = out_entry_reg.cost;
    assign hit_dest    = out_entry_reg.dest;
    assign hit_mask    = out_entry_reg.mask;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("route count beyond table depth");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != IDLE) |-> in_stall)
        else $error("input not stalled during a scan");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_ADD) && (count_reg != FULL_COUNT))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)) && out_valid_reg
            && (status_reg == ST_ADDED))
        else $error("add not recorded");

    a_hit_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_HIT)) |-> (out_entry_reg.cost < COST_LIMIT))
        else $error("chosen route above metric limit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_HIT)) |-> (out_entry_reg == '0))
        else $error("non-hit result carries route fields");
`endif

endmodule

>>> sv/iprt_table_mem.sv
// route table storage, one write port and one registered read port
`timescale 1ns / 1ps

module iprt_table_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  iprt_pkg::entry_t  wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output iprt_pkg::entry_t  rd_data
);
    import iprt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/iprt_match_unit.sv
// shared match and compare unit, keeps the best route seen during a scan
`timescale 1ns / 1ps

module iprt_match_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  iprt_pkg::match_ctl_t         ctl,
    input  logic [iprt_pkg::ADDR_W-1:0]  addr,
    input  iprt_pkg::entry_t             entry,
    output iprt_pkg::match_res_t         res
);
    import iprt_pkg::*;

    logic              found_reg;
    logic [COST_W-1:0] best_cost_reg;
    entry_t            best_entry_reg;
    logic              hit;
    logic              better;

    assign hit    = ((addr ^ entry.dest) & entry.mask) == '0;
    // strict less-than keeps the earliest of equal metrics
    assign better = ctl.step && hit && (entry.cost < best_cost_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            best_cost_reg <= COST_LIMIT;
        end
        else if (ctl.clear)
        begin
            found_reg     <= 1'b0;
            best_cost_reg <= COST_LIMIT;
        end
        else if (better)
        begin
            found_reg     <= 1'b1;
            best_cost_reg <= entry.cost;
        end
    end

    always_ff @(posedge clk)
    begin
        if (better)
        begin
            best_entry_reg <= entry;
        end
    end

    assign res.found = found_reg;
    assign res.entry = best_entry_reg;

endmodule

>>> tb/ipv4_route_table_lookup_tb.sv
// self-checking testbench for the ipv4 route table lookup
`timescale 1ns / 1ps

module ipv4_route_table_lookup_tb;
    import iprt_pkg::*;

    localparam int TABLE_DEPTH     = DEF_TABLE_DEPTH;
    localparam int RANDOM_ITEMS    = 680;
    localparam int PHASE_LEN       = 40;
    localparam int HOLD_AT         = 150;
    localparam int HOLD_CYCLES     = 150;
    localparam int DRAIN_AT        = 400;
    localparam int TAIL_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 30;

    typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_t;

    typedef struct {
        route_op_t          op;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gateway;
        logic [IFACE_W-1:0] iface;
        logic [COST_W-1:0]  cost;
    } route_item_t;

    typedef struct {
        route_status_t      status;
        logic [ADDR_W-1:0]  gateway;
        logic [IFACE_W-1:0] iface;
        logic [COST_W-1:0]  cost;
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
    } route_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                operation = 1'b0;
    logic [ADDR_W-1:0]   dest_addr = '0;
    logic [ADDR_W-1:0]   net_mask = '0;
    logic [ADDR_W-1:0]   next_hop = '0;
    logic [IFACE_W-1:0]  iface_index = '0;
    logic [COST_W-1:0]   route_cost = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          status;
    logic [ADDR_W-1:0]   hit_gateway;
    logic [IFACE_W-1:0]  hit_iface;
    logic [COST_W-1:0]   hit_cost;
    logic [ADDR_W-1:0]   hit_dest;
    logic [ADDR_W-1:0]   hit_mask;

    ipv4_route_table_lookup #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .dest_addr(dest_addr),
        .net_mask(net_mask),
        .next_hop(next_hop),
        .iface_index(iface_index),
        .route_cost(route_cost),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .hit_gateway(hit_gateway),
        .hit_iface(hit_iface),
        .hit_cost(hit_cost),
        .hit_dest(hit_dest),
        .hit_mask(hit_mask)
    );

    route_item_t  route_items[$];
    route_reply_t awaited_replies[$];
    entry_t       planned_routes[$];

    // shadow of the routing table, updated as items are accepted
    entry_t       shadow_table[TABLE_DEPTH];
    int           shadow_fill = 0;

    route_item_t  cur_item;
    int           total_items = 0;
    int           accepted_cnt = 0;
    int           seen_cnt = 0;
    int           quiet_cycles = 0;
    int           mismatches = 0;
    int           hold_left = 0;
    logic         hold_done = 1'b0;
    logic         drain_done = 1'b0;
    int           n_added = 0;
    int           n_full = 0;
    int           n_hit = 0;
    int           n_miss = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic route_reply_t route_reply(route_item_t it);
        route_reply_t     rp;
        logic [COST_W-1:0] best_cost;
        int               best;
        logic             found;
        rp.status  = ST_ADDED;
        rp.gateway = '0;
        rp.iface   = '0;
        rp.cost    = '0;
        rp.dest    = '0;
        rp.mask    = '0;
        if (it.op == OP_ADD)
        begin
            if (shadow_fill >= TABLE_DEPTH)
                rp.status = ST_FULL;
            else
            begin
                shadow_table[shadow_fill] = '{dest: it.addr, mask: it.mask,
                    gateway: it.gateway, iface: it.iface, cost: it.cost};
                shadow_fill++;
            end
        end
        else
        begin
            best_cost = COST_LIMIT;
            best      = 0;
            found     = 1'b0;
            // strict compare keeps the earliest route on a tie
            for (int i = 0; i < shadow_fill; i++)
                if (((it.addr ^ shadow_table[i].dest) & shadow_table[i].mask) == '0
                        && shadow_table[i].cost < best_cost)
                begin
                    best_cost = shadow_table[i].cost;
                    best      = i;
                    found     = 1'b1;
                end
            if (found)
            begin
                rp.status  = ST_HIT;
                rp.gateway = shadow_table[best].gateway;
                rp.iface   = shadow_table[best].iface;
                rp.cost    = shadow_table[best].cost;
                rp.dest    = shadow_table[best].dest;
                rp.mask    = shadow_table[best].mask;
            end
            else
                rp.status = ST_MISS;
        end
        return rp;
    endfunction

    task automatic push_item(route_op_t op, logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] mask,
                             logic [ADDR_W-1:0] gw, logic [IFACE_W-1:0] ifc,
                             logic [COST_W-1:0] cost);
        route_items.push_back('{op: op, addr: addr, mask: mask, gateway: gw, iface: ifc,
                                cost: cost});
        if (op == OP_ADD && planned_routes.size() < TABLE_DEPTH)
            planned_routes.push_back('{dest: addr, mask: mask, gateway: gw, iface: ifc,
                                       cost: cost});
    endtask

    // addresses clustered around a few private prefixes so routes overlap
    function automatic logic [ADDR_W-1:0] near_addr();
        logic [ADDR_W-1:0] lo;
        lo = $urandom;
        case ($urandom_range(0, 3))
            0: return {16'h0A00, lo[15:0]};
            1: return {16'hC0A8, lo[15:0]};
            2: return {12'hAC1, lo[19:0]};
            default: return {8'h0A, lo[23:0]};
        endcase
    endfunction

    function automatic idle_phase_t idle_phase();
        return idle_phase_t'((accepted_cnt / PHASE_LEN) % 4);
    endfunction

    task automatic check_field(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        if (got !== want)
        begin
            if (mismatches < REPORT_LIMIT)
                $display("%0t: reply %0d %s mismatch, expected %h got %h",
                         $time, seen_cnt, what, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        logic take;
        logic offer;
        int   acc_now;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            take    = in_valid && !in_stall;
            acc_now = accepted_cnt;
            if (take)
            begin
                awaited_replies.push_back(route_reply(cur_item));
                acc_now++;
                accepted_cnt <= acc_now;
            end
            if (!in_valid || take)
            begin
                if (!drain_done && acc_now >= DRAIN_AT)
                begin
                    // sender pause until every reply is back
                    offer = 1'b0;
                    if (!take && seen_cnt == accepted_cnt)
                        drain_done <= 1'b1;
                end
                else if (route_items.size() == 0)
                    offer = 1'b0;
                else if (idle_phase() == PH_SEND)
                    offer = $urandom_range(0, 99) >= 68;
                else if (idle_phase() == PH_BOTH)
                    offer = $urandom_range(0, 99) >= 25;
                else
                    offer = 1'b1;
                if (offer)
                begin
                    cur_item = route_items.pop_front();
                    operation   <= cur_item.op;
                    dest_addr   <= cur_item.addr;
                    net_mask    <= cur_item.mask;
                    next_hop    <= cur_item.gateway;
                    iface_index <= cur_item.iface;
                    route_cost  <= cur_item.cost;
                end
                in_valid <= offer;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk)
    begin
        route_reply_t want;
        logic         stall_next;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_cnt <= seen_cnt + 1;
                if (awaited_replies.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: reply with no item awaiting it, status %0d",
                                 $time, status);
                    mismatches++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    case (want.status)
                        ST_ADDED: n_added++;
                        ST_FULL:  n_full++;
                        ST_HIT:   n_hit++;
                        default:  n_miss++;
                    endcase
                    check_field("status", ADDR_W'(want.status), ADDR_W'(status));
                    check_field("hit_gateway", want.gateway, hit_gateway);
                    check_field("hit_iface", ADDR_W'(want.iface), ADDR_W'(hit_iface));
                    check_field("hit_cost", ADDR_W'(want.cost), ADDR_W'(hit_cost));
                    check_field("hit_dest", want.dest, hit_dest);
                    check_field("hit_mask", want.mask, hit_mask);
                end
            end
            if (hold_left > 0)
            begin
                stall_next = 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && accepted_cnt >= HOLD_AT)
            begin
                // long hold-off so the block backs up into its input
                stall_next = 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (idle_phase() == PH_RECV)
                stall_next = $urandom_range(0, 99) < 68;
            else if (idle_phase() == PH_BOTH)
                stall_next = $urandom_range(0, 99) < 25;
            else
                stall_next = 1'b0;
            out_stall <= stall_next;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        route_op_t         op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
        logic [COST_W-1:0] cost;
        entry_t            pick;
        int                len;

        // lookups on an empty table
        push_item(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 2'd0, 14'd0);
        push_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 2'd3, 14'h3FFF);
        // default route with a metric too high to be chosen
        push_item(OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'hC0A8_0001, 2'd0, 14'd9999);
        push_item(OP_LOOKUP, 32'h5A5A_A5A5, 32'h0, 32'h0, 2'd0, 14'd0);
        // all-ones route at the top metric
        push_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 14'h3FFF);
        push_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 2'd0, 14'd0);
        push_item(OP_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 2'd1, 14'd100);
        push_item(OP_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 2'd2, 14'd50);
        // duplicate route on an equal metric, the earlier one must win
        push_item(OP_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 2'd3, 14'd50);
        push_item(OP_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 2'd0, 14'd0);
        push_item(OP_LOOKUP, 32'h0A02_0304, 32'h0, 32'h0, 2'd0, 14'd0);
        push_item(OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0101_0101, 2'd3, 14'd9998);
        push_item(OP_LOOKUP, 32'h0808_0808, 32'h0, 32'h0, 2'd0, 14'd0);
        push_item(OP_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0000_0000, 2'd0, 14'd0);
        push_item(OP_LOOKUP, 32'hC0A8_01FF, 32'h0, 32'h0, 2'd0, 14'd0);
        // non-contiguous mask
        push_item(OP_ADD, 32'h1234_5678, 32'h00FF_00FF, 32'h8765_4321, 2'd1, 14'd7);
        push_item(OP_LOOKUP, 32'hAB34_CD78, 32'h0, 32'h0, 2'd0, 14'd0);
        push_item(OP_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 2'd0, 14'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) < (planned_routes.size() < TABLE_DEPTH ? 25 : 12))
                op = OP_ADD;
            else
                op = OP_LOOKUP;
            case ($urandom_range(0, 9))
                0: mask = '0;
                1: mask = '1;
                2, 3: mask = $urandom;
                default:
                begin
                    len  = $urandom_range(1, 31);
                    mask = ~32'h0 << (32 - len);
                end
            endcase
            case ($urandom_range(0, 9))
                0: cost = '0;
                1: cost = 14'd9998;
                2: cost = 14'd9999;
                3: cost = 14'h3FFF;
                4, 5, 6: cost = COST_W'($urandom_range(0, 20));
                default: cost = COST_W'($urandom_range(0, 16383));
            endcase
            if (op == OP_ADD)
                addr = $urandom_range(0, 1) ? near_addr() : $urandom;
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                    begin
                        // aim at a route already in the table
                        pick = planned_routes[$urandom_range(0, planned_routes.size() - 1)];
                        addr = (pick.dest & pick.mask) | ($urandom & ~pick.mask);
                    end
                    11, 12, 13, 14, 15, 16: addr = near_addr();
                    default: addr = $urandom;
                endcase
            end
            push_item(op, addr, mask, $urandom, IFACE_W'($urandom_range(0, 3)), cost);
        end
        total_items = route_items.size();

        while (!(accepted_cnt == total_items && seen_cnt == accepted_cnt)
               && quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        if (quiet_cycles < WATCHDOG_LIMIT)
            repeat (TAIL_CYCLES) @(posedge clk);

        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d of %0d items accepted",
                     $time, quiet_cycles, accepted_cnt, total_items);
            $display("TB_ERROR");
        end
        else
        begin
            $display("run covered %0d items: %0d routes added, %0d adds dropped on a full table",
                     total_items, n_added, n_full);
            $display("lookups: %0d hits, %0d misses, %0d mismatches",
                     n_hit, n_miss, mismatches);
            if (mismatches == 0 && awaited_replies.size() == 0)
                $display("TB_OK");
            else
                $display("TB_ERROR");
        end
        $finish;
    end

endmodule
